/* rtl/cia_pkg.sv */
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants of the complex integer ALU
// Operation codes, result width and the side data that rides the divider row.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int OperandWidthDefault = 16;
    localparam int ResWidth            = 33;
    localparam int ModeWidth           = 3;

    typedef enum logic [ModeWidth-1:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_CONJ = 3'd4
    } t_mode;

    // Side data carried alongside the quotient bits through the divider row.
    typedef struct packed {
        logic                        is_div;
        logic                        div_zero;
        logic                        neg_re;
        logic                        neg_im;
        logic signed [ResWidth-1:0]  byp_re;
        logic signed [ResWidth-1:0]  byp_im;
    } t_meta;

endpackage

/* rtl/complex_integer_alu.sv */
// ----------------------------------------------------------------------------
// complex_integer_alu: pipelined arithmetic unit for signed complex integers
// Add, subtract, multiply, divide and conjugate on two complex operands.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  request   in         i_s_tvalid/o_s_tready  tdata: a_re,a_im,b_re,b_im; tuser: mode
//  result    out        o_m_tvalid/i_m_tready  tdata: res_re,res_im; tuser: div_error
//
// The unit accepts one request per clock cycle while the pipeline is not
// held. Each request passes through stages 1 to 3, a divider row of
// 2*OPERAND_WIDTH cells that each resolve one quotient bit per lane, and
// the output register. All operations travel through the
// same pipeline so results leave in request order. Reset is synchronous
// and active low; it clears only the valid bits. When the output register
// is full and the consumer is not ready, the whole pipeline holds.
//
module complex_integer_alu #(
    parameter int OPERAND_WIDTH = cia_pkg::OperandWidthDefault
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // Fields from bit 0 up: a_re, a_im, b_re, b_im, zero padding.
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]  i_s_tdata,
    // Fields from bit 0 up: mode.
    input  logic [cia_pkg::ModeWidth-1:0]         i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // Fields from bit 0 up: res_re, res_im, zero padding.
    output logic [((2*cia_pkg::ResWidth+7)/8)*8-1:0] o_m_tdata,
    // Fields from bit 0 up: div_error.
    output logic                                  o_m_tuser
);

    localparam int W   = OPERAND_WIDTH;
    localparam int PW  = 2 * W;       // product width, also divider width
    localparam int SW  = 2 * W + 1;   // exact sum of two products
    localparam int RW  = cia_pkg::ResWidth;
    localparam int ODW = ((2 * RW + 7) / 8) * 8;
    localparam int NC  = PW;          // number of divider cells

    // Global advance: everything moves when the output slot is free or draining.
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    logic signed [W-1:0] in_ar, in_ai, in_br, in_bi;
    assign in_ar = i_s_tdata[W-1:0];
    assign in_ai = i_s_tdata[2*W-1:W];
    assign in_br = i_s_tdata[3*W-1:2*W];
    assign in_bi = i_s_tdata[4*W-1:3*W];

    // Stage 1: the six products, registered straight from the request.
    logic                        r1_valid;
    logic [cia_pkg::ModeWidth-1:0] r1_mode;
    logic signed [W-1:0]         r1_ar, r1_ai, r1_br, r1_bi;
    logic signed [PW-1:0]        r1_rr, r1_ii, r1_ri, r1_ir, r1_bbr, r1_bbi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mode <= i_s_tuser;
            r1_ar   <= in_ar;
            r1_ai   <= in_ai;
            r1_br   <= in_br;
            r1_bi   <= in_bi;
            r1_rr   <= in_ar * in_br;
            r1_ii   <= in_ai * in_bi;
            r1_ri   <= in_ar * in_bi;
            r1_ir   <= in_ai * in_br;
            r1_bbr  <= in_br * in_br;
            r1_bbi  <= in_bi * in_bi;
        end
    end

    // Stage 2: exact sums, the denominator, and the results of the simple modes.
    logic signed [SW-1:0] e_ar, e_ai, e_br, e_bi, e_rr, e_ii, e_ri, e_ir;
    logic signed [SW-1:0] n_num_re, n_num_im;
    logic [PW-1:0]        n_den;
    logic signed [RW-1:0] n_byp_re, n_byp_im;
    logic                 n_is_div;

    assign e_ar = SW'(r1_ar);
    assign e_ai = SW'(r1_ai);
    assign e_br = SW'(r1_br);
    assign e_bi = SW'(r1_bi);
    assign e_rr = SW'(r1_rr);
    assign e_ii = SW'(r1_ii);
    assign e_ri = SW'(r1_ri);
    assign e_ir = SW'(r1_ir);

    always_comb begin
        n_num_re = e_rr + e_ii;
        n_num_im = e_ir - e_ri;
        n_den    = r1_bbr + r1_bbi;
        n_is_div = 1'b0;
        n_byp_re = '0;
        n_byp_im = '0;
        unique case (r1_mode)
            cia_pkg::MODE_ADD: begin
                n_byp_re = RW'(e_ar + e_br);
                n_byp_im = RW'(e_ai + e_bi);
            end
            cia_pkg::MODE_SUB: begin
                n_byp_re = RW'(e_ar - e_br);
                n_byp_im = RW'(e_ai - e_bi);
            end
            cia_pkg::MODE_MUL: begin
                n_byp_re = RW'(e_rr - e_ii);
                n_byp_im = RW'(e_ri + e_ir);
            end
            cia_pkg::MODE_DIV: begin
                n_is_div = 1'b1;
            end
            cia_pkg::MODE_CONJ: begin
                n_byp_re = RW'(e_ar);
                n_byp_im = RW'(-e_ai);
            end
            default: begin
                // Unused codes give a zero result without an error.
            end
        endcase
    end

    logic                 r2_valid, r2_is_div;
    logic signed [SW-1:0] r2_num_re, r2_num_im;
    logic [PW-1:0]        r2_den;
    logic signed [RW-1:0] r2_byp_re, r2_byp_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_is_div <= n_is_div;
            r2_num_re <= n_num_re;
            r2_num_im <= n_num_im;
            r2_den    <= n_den;
            r2_byp_re <= n_byp_re;
            r2_byp_im <= n_byp_im;
        end
    end

    // Stage 3: split numerators into sign and magnitude for the divider.
    // The magnitude of either numerator never exceeds 2^(2W-1), so PW bits hold it.
    logic           r3_valid;
    logic [PW-1:0]  r3_mag_re, r3_mag_im, r3_den;
    cia_pkg::t_meta r3_meta;
    logic [SW-1:0]  neg_num_re, neg_num_im;

    assign neg_num_re = -r2_num_re;
    assign neg_num_im = -r2_num_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mag_re <= r2_num_re[SW-1] ? neg_num_re[PW-1:0] : r2_num_re[PW-1:0];
            r3_mag_im <= r2_num_im[SW-1] ? neg_num_im[PW-1:0] : r2_num_im[PW-1:0];
            r3_den    <= r2_den;
            r3_meta.is_div   <= r2_is_div;
            r3_meta.div_zero <= (r2_den == '0);
            r3_meta.neg_re   <= r2_num_re[SW-1];
            r3_meta.neg_im   <= r2_num_im[SW-1];
            r3_meta.byp_re   <= r2_byp_re;
            r3_meta.byp_im   <= r2_byp_im;
        end
    end

    // Divider row: cell k resolves quotient bit PW-1-k of both lanes.
    logic           c_valid  [NC+1];
    logic [PW-1:0]  c_den    [NC+1];
    logic [PW-1:0]  c_rem_re [NC+1];
    logic [PW-1:0]  c_nq_re  [NC+1];
    logic [PW-1:0]  c_rem_im [NC+1];
    logic [PW-1:0]  c_nq_im  [NC+1];
    cia_pkg::t_meta c_meta   [NC+1];

    assign c_valid[0]  = r3_valid;
    assign c_den[0]    = r3_den;
    assign c_rem_re[0] = '0;
    assign c_nq_re[0]  = r3_mag_re;
    assign c_rem_im[0] = '0;
    assign c_nq_im[0]  = r3_mag_im;
    assign c_meta[0]   = r3_meta;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        cia_div_cell #(
            .NW (PW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (c_valid[k]),
            .i_den    (c_den[k]),
            .i_rem_re (c_rem_re[k]),
            .i_nq_re  (c_nq_re[k]),
            .i_rem_im (c_rem_im[k]),
            .i_nq_im  (c_nq_im[k]),
            .i_meta   (c_meta[k]),
            .o_valid  (c_valid[k+1]),
            .o_den    (c_den[k+1]),
            .o_rem_re (c_rem_re[k+1]),
            .o_nq_re  (c_nq_re[k+1]),
            .o_rem_im (c_rem_im[k+1]),
            .o_nq_im  (c_nq_im[k+1]),
            .o_meta   (c_meta[k+1])
        );
    end

    // Output stage: restore the quotient signs and pick the result of the mode.
    cia_pkg::t_meta       fm;
    logic signed [SW-1:0] q_re, q_im;
    logic signed [RW-1:0] n_res_re, n_res_im;
    logic                 n_err;

    assign fm   = c_meta[NC];
    assign q_re = fm.neg_re ? -SW'(c_nq_re[NC]) : SW'(c_nq_re[NC]);
    assign q_im = fm.neg_im ? -SW'(c_nq_im[NC]) : SW'(c_nq_im[NC]);

    always_comb begin
        n_err    = 1'b0;
        n_res_re = fm.byp_re;
        n_res_im = fm.byp_im;
        if (fm.is_div) begin
            if (fm.div_zero) begin
                // Division by zero returns zero parts and raises the flag.
                n_err    = 1'b1;
                n_res_re = '0;
                n_res_im = '0;
            end else begin
                n_res_re = RW'(q_re);
                n_res_im = RW'(q_im);
            end
        end
    end

    logic                 r_out_valid, r_out_err;
    logic signed [RW-1:0] r_out_re, r_out_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_valid[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_re  <= n_res_re;
            r_out_im  <= n_res_im;
            r_out_err <= n_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = ODW'({r_out_im, r_out_re});
    assign o_m_tuser  = r_out_err;

endmodule

/* rtl/cia_div_cell.sv */
// ----------------------------------------------------------------------------
// cia_div_cell: one restoring division step for two lanes
// Produces one quotient bit per lane and hands the partial state onward.
// ----------------------------------------------------------------------------
module cia_div_cell #(
    parameter int NW = 2 * cia_pkg::OperandWidthDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [NW-1:0]  i_den,
    input  logic [NW-1:0]  i_rem_re,
    input  logic [NW-1:0]  i_nq_re,
    input  logic [NW-1:0]  i_rem_im,
    input  logic [NW-1:0]  i_nq_im,
    input  cia_pkg::t_meta i_meta,
    output logic           o_valid,
    output logic [NW-1:0]  o_den,
    output logic [NW-1:0]  o_rem_re,
    output logic [NW-1:0]  o_nq_re,
    output logic [NW-1:0]  o_rem_im,
    output logic [NW-1:0]  o_nq_im,
    output cia_pkg::t_meta o_meta
);

    logic [NW-1:0]  r_den, r_rem_re, r_nq_re, r_rem_im, r_nq_im;
    logic [NW-1:0]  n_rem_re, n_nq_re, n_rem_im, n_nq_im;
    logic           r_valid;
    cia_pkg::t_meta r_meta;

    // Shift the next numerator bit into the remainder and try a subtract.
    function automatic logic [2*NW-1:0] div_step(input logic [NW-1:0] rem,
                                                 input logic [NW-1:0] nq,
                                                 input logic [NW-1:0] den);
        logic [NW:0] t;
        logic [NW:0] d;
        t = {rem, nq[NW-1]};
        d = t - {1'b0, den};
        if (!d[NW]) begin
            div_step = {d[NW-1:0], nq[NW-2:0], 1'b1};
        end else begin
            div_step = {t[NW-1:0], nq[NW-2:0], 1'b0};
        end
    endfunction

    always_comb begin
        {n_rem_re, n_nq_re} = div_step(i_rem_re, i_nq_re, i_den);
        {n_rem_im, n_nq_im} = div_step(i_rem_im, i_nq_im, i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den    <= i_den;
            r_rem_re <= n_rem_re;
            r_nq_re  <= n_nq_re;
            r_rem_im <= n_rem_im;
            r_nq_im  <= n_nq_im;
            r_meta   <= i_meta;
        end
    end

    assign o_valid  = r_valid;
    assign o_den    = r_den;
    assign o_rem_re = r_rem_re;
    assign o_nq_re  = r_nq_re;
    assign o_rem_im = r_rem_im;
    assign o_nq_im  = r_nq_im;
    assign o_meta   = r_meta;

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the complex integer ALU
// Drives directed and random complex requests through the stream interface,
// predicts each result in the bench and compares it field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int OW = cia_pkg::OperandWidthDefault;
    localparam int MW = cia_pkg::ModeWidth;
    localparam int RS = cia_pkg::ResWidth;
    localparam int DW = ((4*OW+7)/8)*8;
    localparam int RW = ((2*RS+7)/8)*8;
    localparam int LATENCY = 4 + 2*OW;
    localparam int RANDOM_COUNT = 1650;

    typedef struct packed {
        logic [MW-1:0] mode;
        logic signed [OW-1:0] a_re, a_im, b_re, b_im;
    } t_req;

    typedef struct packed {
        logic signed [RS-1:0] re;
        logic signed [RS-1:0] im;
        logic                 err;
    } t_res;

    // One row of the directed table; known marks a typed-in expectation.
    typedef struct {
        t_req req;
        bit   known;
        t_res res;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [DW-1:0] i_s_tdata = '0;
    logic [MW-1:0] i_s_tuser = '0;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [RW-1:0] o_m_tdata;
    logic          o_m_tuser;

    t_res pending_results[$];
    int   error_count = 0;
    int   result_count = 0;
    bit   sink_quiet = 1'b0;   // no stalls on the result side
    bit   long_hold = 1'b0;    // request for one long stall
    int   div_zero_count = 0;

    complex_integer_alu #(.OPERAND_WIDTH(OW)) u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // Truncating signed division of exact 64-bit values.
    function automatic logic signed [63:0] quot_trunc(logic signed [63:0] num,
                                                      logic signed [63:0] den);
        logic [63:0] mag;
        logic [63:0] q;
        mag = num < 0 ? -num : num;
        q   = mag / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic t_res complex_result(t_req r);
        logic signed [63:0] ar, ai, br, bi, den;
        logic signed [63:0] re, im;
        t_res o;
        ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
        re = 0; im = 0; o.err = 1'b0;
        case (r.mode)
            cia_pkg::MODE_ADD: begin re = ar + br; im = ai + bi; end
            cia_pkg::MODE_SUB: begin re = ar - br; im = ai - bi; end
            cia_pkg::MODE_MUL: begin
                re = ar*br - ai*bi;
                im = ar*bi + ai*br;
            end
            cia_pkg::MODE_DIV: begin
                den = br*br + bi*bi;
                if (den == 0) begin
                    o.err = 1'b1;
                end else begin
                    re = quot_trunc(ar*br + ai*bi, den);
                    im = quot_trunc(ai*br - ar*bi, den);
                end
            end
            cia_pkg::MODE_CONJ: begin re = ar; im = -ai; end
            default: ;
        endcase
        o.re = re[RS-1:0];
        o.im = im[RS-1:0];
        return o;
    endfunction

    // Offers one request and waits until it is accepted.
    task automatic send_request(t_req r, t_res exp_res);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= r.mode;
        i_s_tdata  <= {r.b_im, r.b_re, r.a_im, r.a_re};
        pending_results.push_back(exp_res);
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic idle_source(int cycles);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic signed [OW-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(OW-1){1'b0}}};
            1: return {1'b0, {(OW-1){1'b1}}};
            2: return '0;
            3: return OW'($urandom_range(0, 6) - 3);
            default: return OW'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random ready, one long stall on request.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_m_tready <= 1'b0;
                repeat (200) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!sink_quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 15);
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Checks every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.re  = o_m_tdata[RS-1:0];
            got.im  = o_m_tdata[2*RS-1:RS];
            got.err = o_m_tuser;
            result_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: re %0d im %0d err %0b",
                         $realtime, got.re, got.im, got.err);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.re !== want.re) begin
                    $display("%0t: res_re expected %0d actual %0d",
                             $realtime, want.re, got.re);
                    error_count++;
                end
                if (got.im !== want.im) begin
                    $display("%0t: res_im expected %0d actual %0d",
                             $realtime, want.im, got.im);
                    error_count++;
                end
                if (got.err !== want.err) begin
                    $display("%0t: div_error expected %0b actual %0b",
                             $realtime, want.err, got.err);
                    error_count++;
                end
            end
        end
    end

    initial begin
        localparam logic signed [OW-1:0] MX = {1'b0, {(OW-1){1'b1}}};
        localparam logic signed [OW-1:0] MN = {1'b1, {(OW-1){1'b0}}};
        t_row table_rows[$];
        t_req r;
        t_res e;
        int waited;

        // Directed table: mode, a_re, a_im, b_re, b_im, typed-in flag and result.
        table_rows = '{
            '{'{cia_pkg::MODE_ADD, MX, MX, MX, MX}, 1, '{65534, 65534, 0}},
            '{'{cia_pkg::MODE_ADD, MN, MN, MN, MN}, 1, '{-65536, -65536, 0}},
            '{'{cia_pkg::MODE_SUB, MX, MN, MN, MX}, 1, '{65535, -65535, 0}},
            '{'{cia_pkg::MODE_SUB, MN, MX, MX, MN}, 1, '{-65535, 65535, 0}},
            '{'{cia_pkg::MODE_MUL, MN, MN, MN, MN}, 1, '{0, 33'sd2147483648, 0}},
            '{'{cia_pkg::MODE_MUL, MN, MX, MN, MN}, 0, '{0, 0, 0}},
            '{'{cia_pkg::MODE_MUL, MX, MX, MX, MN}, 0, '{0, 0, 0}},
            '{'{cia_pkg::MODE_DIV, MX, MX, 0, 0}, 1, '{0, 0, 1}},
            '{'{cia_pkg::MODE_DIV, 0, 0, 0, 0}, 1, '{0, 0, 1}},
            '{'{cia_pkg::MODE_DIV, MN, MN, 1, 0}, 1, '{-32768, -32768, 0}},
            '{'{cia_pkg::MODE_DIV, MN, MN, MN, MN}, 0, '{0, 0, 0}},
            '{'{cia_pkg::MODE_DIV, 7, -7, 2, 0}, 0, '{0, 0, 0}},
            '{'{cia_pkg::MODE_DIV, -7, 7, 0, 2}, 0, '{0, 0, 0}},
            '{'{cia_pkg::MODE_DIV, MX, MN, MN, MX}, 0, '{0, 0, 0}},
            '{'{cia_pkg::MODE_CONJ, MN, MN, 5, 5}, 1, '{-32768, 32768, 0}},
            '{'{cia_pkg::MODE_CONJ, MX, MX, 0, 0}, 1, '{32767, -32767, 0}},
            '{'{cia_pkg::MODE_SUB, 0, 0, 0, 0}, 1, '{0, 0, 0}},
            '{'{3'd5, MX, MX, MX, MX}, 1, '{0, 0, 0}},
            '{'{3'd6, MN, MN, 0, 0}, 1, '{0, 0, 0}},
            '{'{3'd7, -1, -1, -1, -1}, 1, '{0, 0, 0}},
            '{'{cia_pkg::MODE_MUL, -1, -1, -1, -1}, 1, '{0, 2, 0}}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[k]) begin
            e = table_rows[k].known ? table_rows[k].res : complex_result(table_rows[k].req);
            send_request(table_rows[k].req, e);
        end

        for (int n = 0; n < RANDOM_COUNT; n++) begin
            r.mode = ($urandom_range(0, 9) == 0) ? MW'($urandom_range(5, 7))
                                                  : MW'($urandom_range(0, 4));
            r.a_re = pick_operand(); r.a_im = pick_operand();
            r.b_re = pick_operand(); r.b_im = pick_operand();
            if (r.mode == cia_pkg::MODE_DIV && r.b_re == 0 && r.b_im == 0)
                div_zero_count++;
            if (n == 400) long_hold = 1'b1;   // sender keeps offering meanwhile
            if (n == 800) begin
                i_s_tvalid <= 1'b0;
                wait_drained();
            end
            if (n == RANDOM_COUNT - 200) sink_quiet = 1'b1;
            if (!sink_quiet && $urandom_range(0, 7) == 0)
                idle_source($urandom_range(1, 15));
            send_request(r, complex_result(r));
        end
        i_s_tvalid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2*LATENCY) @(posedge i_clk);

        $display("Ran %0d directed and %0d random requests over all modes, %0d results",
                 table_rows.size(), RANDOM_COUNT, result_count);
        $display("including %0d random divides by zero and a long result-side stall",
                 div_zero_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
